// ----- hdl/rdd_pkg.sv -----
`timescale 1ns / 1ps
package rdd_pkg;

  localparam logic [1:0] MODE_REQUEST = 2'd0;
  localparam logic [1:0] MODE_ALLOC   = 2'd1;
  localparam logic [1:0] MODE_DEALLOC = 2'd2;
  localparam logic [1:0] MODE_DETECT  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_DET_RUN,
    ST_DET_TAIL,
    ST_DET_EVAL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic init;
    logic clear_changed;
    logic check;
  } prune_ctl_t;

  typedef struct packed {
    logic changed;
    logic any_left;
  } prune_sts_t;

endpackage

// ----- hdl/rag_deadlock_detector_unit.sv -----
`timescale 1ns / 1ps
// Resource allocation graph deadlock detector. Request edges (process to lock)
// live in one RAM row per process, allocation edges (lock to process) in one
// RAM row per lock; a flop per row marks rows written since reset, so no
// clearing pass is needed. An edge update reads both rows and writes them back
// in the next cycle. A detect sweeps both RAMs together, one row of each per
// cycle, dropping every node with no edge to a surviving node, and repeats
// sweeps until one drops nothing; it answers 1 if any node survives. At most
// NUM_PROCS + NUM_LOCKS + 1 sweeps run; the single RAM read port per matrix
// is why a sweep reads one row of each at a time. One item is in work at a
// time; the result register lets the next item enter while a result waits.
module rag_deadlock_detector_unit
  import rdd_pkg::*;
#(
  parameter int NUM_LOCKS = 16,
  parameter int NUM_PROCS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [4:0] proc_id,
  input  logic [3:0] lock_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       deadlock
);

  localparam int SWEEP_LEN = (NUM_LOCKS > NUM_PROCS) ? NUM_LOCKS : NUM_PROCS;
  localparam int SW_AW = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1;
  localparam int PROC_AW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int LOCK_AW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;

  logic                 req_we, hold_we;
  logic [PROC_AW-1:0]   req_waddr, req_raddr;
  logic [LOCK_AW-1:0]   hold_waddr, hold_raddr;
  logic [NUM_LOCKS-1:0] req_wdata, req_rdata, req_row;
  logic [NUM_PROCS-1:0] hold_wdata, hold_rdata, hold_row;
  prune_ctl_t           prune_ctl;
  prune_sts_t           prune_sts;
  logic [SW_AW-1:0]     chk_idx;

  rdd_ram #(.WIDTH(NUM_LOCKS), .DEPTH(NUM_PROCS)) u_req_ram (
    .clk   (clk),
    .we    (req_we),
    .waddr (req_waddr),
    .wdata (req_wdata),
    .raddr (req_raddr),
    .rdata (req_rdata)
  );

  rdd_ram #(.WIDTH(NUM_PROCS), .DEPTH(NUM_LOCKS)) u_hold_ram (
    .clk   (clk),
    .we    (hold_we),
    .waddr (hold_waddr),
    .wdata (hold_wdata),
    .raddr (hold_raddr),
    .rdata (hold_rdata)
  );

  rdd_prune #(.NUM_LOCKS(NUM_LOCKS), .NUM_PROCS(NUM_PROCS)) u_prune (
    .clk      (clk),
    .rst      (rst),
    .ctl      (prune_ctl),
    .chk_idx  (chk_idx),
    .req_row  (req_row),
    .hold_row (hold_row),
    .sts      (prune_sts)
  );

  rdd_ctrl #(.NUM_LOCKS(NUM_LOCKS), .NUM_PROCS(NUM_PROCS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .proc_id    (proc_id),
    .lock_id    (lock_id),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .deadlock   (deadlock),
    .req_we     (req_we),
    .req_waddr  (req_waddr),
    .req_wdata  (req_wdata),
    .req_raddr  (req_raddr),
    .req_rdata  (req_rdata),
    .hold_we    (hold_we),
    .hold_waddr (hold_waddr),
    .hold_wdata (hold_wdata),
    .hold_raddr (hold_raddr),
    .hold_rdata (hold_rdata),
    .prune_ctl  (prune_ctl),
    .chk_idx    (chk_idx),
    .req_row    (req_row),
    .hold_row   (hold_row),
    .prune_sts  (prune_sts)
  );

endmodule

// ----- hdl/rdd_ram.sv -----
`timescale 1ns / 1ps
module rdd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/rdd_prune.sv -----
`timescale 1ns / 1ps
module rdd_prune
  import rdd_pkg::*;
#(
  parameter int NUM_LOCKS = 16,
  parameter int NUM_PROCS = 32,
  localparam int SWEEP_LEN = (NUM_LOCKS > NUM_PROCS) ? NUM_LOCKS : NUM_PROCS,
  localparam int SW_AW = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1,
  localparam int PROC_AW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1,
  localparam int LOCK_AW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  prune_ctl_t           ctl,
  input  logic [SW_AW-1:0]     chk_idx,
  input  logic [NUM_LOCKS-1:0] req_row,
  input  logic [NUM_PROCS-1:0] hold_row,
  output prune_sts_t           sts
);

  logic [NUM_PROCS-1:0] procs_left;
  logic [NUM_LOCKS-1:0] locks_left;
  logic                 changed;
  logic                 proc_in, lock_in;
  logic [PROC_AW-1:0]   proc_sel;
  logic [LOCK_AW-1:0]   lock_sel;
  logic                 proc_drop, lock_drop;

  always_comb begin
    proc_in   = 32'(chk_idx) < NUM_PROCS;
    lock_in   = 32'(chk_idx) < NUM_LOCKS;
    proc_sel  = proc_in ? PROC_AW'(chk_idx) : '0;
    lock_sel  = lock_in ? LOCK_AW'(chk_idx) : '0;
    proc_drop = ctl.check && proc_in && procs_left[proc_sel] &&
                ((req_row & locks_left) == '0);
    lock_drop = ctl.check && lock_in && locks_left[lock_sel] &&
                ((hold_row & procs_left) == '0);
    sts.changed  = changed;
    sts.any_left = (|procs_left) || (|locks_left);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      procs_left <= '0;
      locks_left <= '0;
      changed    <= 1'b0;
    end else if (ctl.init) begin
      procs_left <= '1;
      locks_left <= '1;
      changed    <= 1'b0;
    end else begin
      if (proc_drop) begin
        procs_left[proc_sel] <= 1'b0;
      end
      if (lock_drop) begin
        locks_left[lock_sel] <= 1'b0;
      end
      if (ctl.clear_changed) begin
        changed <= 1'b0;
      end else if (proc_drop || lock_drop) begin
        changed <= 1'b1;
      end
    end
  end

endmodule

// ----- hdl/rdd_ctrl.sv -----
`timescale 1ns / 1ps
module rdd_ctrl
  import rdd_pkg::*;
#(
  parameter int NUM_LOCKS = 16,
  parameter int NUM_PROCS = 32,
  localparam int SWEEP_LEN = (NUM_LOCKS > NUM_PROCS) ? NUM_LOCKS : NUM_PROCS,
  localparam int SW_AW = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1,
  localparam int PROC_AW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1,
  localparam int LOCK_AW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           mode,
  input  logic [4:0]           proc_id,
  input  logic [3:0]           lock_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 deadlock,
  output logic                 req_we,
  output logic [PROC_AW-1:0]   req_waddr,
  output logic [NUM_LOCKS-1:0] req_wdata,
  output logic [PROC_AW-1:0]   req_raddr,
  input  logic [NUM_LOCKS-1:0] req_rdata,
  output logic                 hold_we,
  output logic [LOCK_AW-1:0]   hold_waddr,
  output logic [NUM_PROCS-1:0] hold_wdata,
  output logic [LOCK_AW-1:0]   hold_raddr,
  input  logic [NUM_PROCS-1:0] hold_rdata,
  output prune_ctl_t           prune_ctl,
  output logic [SW_AW-1:0]     chk_idx,
  output logic [NUM_LOCKS-1:0] req_row,
  output logic [NUM_PROCS-1:0] hold_row,
  input  prune_sts_t           prune_sts
);

  state_t               state, state_next;
  logic [1:0]           item_mode;
  logic [4:0]           item_proc;
  logic [3:0]           item_lock;
  logic                 found;
  logic [SW_AW-1:0]     idx;
  logic                 chk_en;
  logic [NUM_PROCS-1:0] req_vld;
  logic [NUM_LOCKS-1:0] hold_vld;
  logic                 req_rvld, hold_rvld;
  logic                 req_re, hold_re;
  logic                 load_out;
  logic                 accept, in_range, idx_last;

  assign accept   = in_valid && !in_stall;
  assign in_range = (32'(proc_id) < NUM_PROCS) && (32'(lock_id) < NUM_LOCKS);
  assign idx_last = idx == SW_AW'(SWEEP_LEN - 1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (mode == MODE_DETECT) begin
            state_next = ST_DET_RUN;
          end else if (in_range) begin
            state_next = ST_UPD_RD;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_UPD_RD:   state_next = ST_UPD_WR;
      ST_UPD_WR:   state_next = ST_FINISH;
      ST_DET_RUN: begin
        if (idx_last) begin
          state_next = ST_DET_TAIL;
        end
      end
      ST_DET_TAIL: state_next = ST_DET_EVAL;
      ST_DET_EVAL: state_next = prune_sts.changed ? ST_DET_RUN : ST_FINISH;
      ST_FINISH: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state != ST_IDLE);
    req_raddr  = '0;
    hold_raddr = '0;
    req_re     = 1'b0;
    hold_re    = 1'b0;
    req_we     = 1'b0;
    hold_we    = 1'b0;
    load_out   = 1'b0;
    prune_ctl  = '0;
    case (state)
      ST_IDLE: begin
        prune_ctl.init = in_valid && (mode == MODE_DETECT);
      end
      ST_UPD_RD: begin
        req_raddr  = PROC_AW'(item_proc);
        hold_raddr = LOCK_AW'(item_lock);
        req_re     = 1'b1;
        hold_re    = 1'b1;
      end
      ST_UPD_WR: begin
        req_we  = 1'b1;
        hold_we = 1'b1;
      end
      ST_DET_RUN: begin
        if (32'(idx) < NUM_PROCS) begin
          req_raddr = PROC_AW'(idx);
          req_re    = 1'b1;
        end
        if (32'(idx) < NUM_LOCKS) begin
          hold_raddr = LOCK_AW'(idx);
          hold_re    = 1'b1;
        end
      end
      ST_DET_EVAL: begin
        prune_ctl.clear_changed = prune_sts.changed;
      end
      ST_FINISH: begin
        load_out = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    prune_ctl.check = chk_en;
  end

  always_comb begin
    req_row    = req_rdata & {NUM_LOCKS{req_rvld}};
    hold_row   = hold_rdata & {NUM_PROCS{hold_rvld}};
    req_waddr  = PROC_AW'(item_proc);
    hold_waddr = LOCK_AW'(item_lock);
    req_wdata  = req_row;
    req_wdata[LOCK_AW'(item_lock)] = (item_mode == MODE_REQUEST);
    hold_wdata = hold_row;
    case (item_mode)
      MODE_ALLOC:   hold_wdata[PROC_AW'(item_proc)] = 1'b1;
      MODE_DEALLOC: hold_wdata[PROC_AW'(item_proc)] = 1'b0;
      default:      hold_wdata = hold_row;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      chk_en    <= 1'b0;
      req_vld   <= '0;
      hold_vld  <= '0;
      req_rvld  <= 1'b0;
      hold_rvld <= 1'b0;
      idx       <= '0;
    end else begin
      state     <= state_next;
      chk_en    <= (state == ST_DET_RUN);
      req_rvld  <= req_re && req_vld[req_raddr];
      hold_rvld <= hold_re && hold_vld[hold_raddr];
      if (req_we) begin
        req_vld[req_waddr] <= 1'b1;
      end
      if (hold_we) begin
        hold_vld[hold_waddr] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept || state == ST_DET_EVAL) begin
        idx <= '0;
      end else if (state == ST_DET_RUN && !idx_last) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= idx;
    if (accept) begin
      item_mode <= mode;
      item_proc <= proc_id;
      item_lock <= lock_id;
      found     <= 1'b0;
    end else if (state == ST_DET_EVAL) begin
      found <= prune_sts.any_left;
    end
    if (load_out) begin
      deadlock <= found;
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import rdd_pkg::*;

  localparam int PROCS = 32;
  localparam int LOCKS = 16;
  localparam int ITEM_TARGET = 650;
  localparam int LONG_HOLD = 600;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 200;

  class deadlock_tracker;
    logic [LOCKS-1:0] wants [PROCS];
    logic [PROCS-1:0] holders [LOCKS];
    bit expected_verdicts [$];
    int verdicts_checked;
    int detects_run;
    int cycles_found;
    int errors;

    function new();
      foreach (wants[k]) wants[k] = '0;
      foreach (holders[k]) holders[k] = '0;
      verdicts_checked = 0;
      detects_run = 0;
      cycles_found = 0;
      errors = 0;
    endfunction

    // prune nodes with no edge to a surviving node until a pass drops nothing
    function bit graph_cycles();
      logic [PROCS-1:0] procs_left, next_procs;
      logic [LOCKS-1:0] locks_left, next_locks;
      int pass, k;
      procs_left = '1;
      locks_left = '1;
      for (pass = 0; pass < PROCS + LOCKS; pass++) begin
        next_procs = procs_left;
        next_locks = locks_left;
        for (k = 0; k < PROCS; k++)
          if (procs_left[k] && (wants[k] & locks_left) == '0) next_procs[k] = 1'b0;
        for (k = 0; k < LOCKS; k++)
          if (locks_left[k] && (holders[k] & procs_left) == '0) next_locks[k] = 1'b0;
        if (next_procs == procs_left && next_locks == locks_left) break;
        procs_left = next_procs;
        locks_left = next_locks;
      end
      return |{procs_left, locks_left};
    endfunction

    function void note_transfer(logic [1:0] op, logic [4:0] p, logic [3:0] l);
      bit verdict;
      verdict = 1'b0;
      if (op == MODE_DETECT) begin
        verdict = graph_cycles();
        detects_run++;
        if (verdict) cycles_found++;
      end else if (p < PROCS && l < LOCKS) begin
        case (op)
          MODE_REQUEST: wants[p][l] = 1'b1;
          MODE_ALLOC: begin
            wants[p][l] = 1'b0;
            holders[l][p] = 1'b1;
          end
          default: begin
            wants[p][l] = 1'b0;
            holders[l][p] = 1'b0;
          end
        endcase
      end
      expected_verdicts.push_back(verdict);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%t: %s", $realtime, msg);
    endfunction

    function void check_verdict(logic got);
      bit want;
      if (expected_verdicts.size() == 0) begin
        flag($sformatf("result with nothing outstanding: deadlock=%b", got));
        return;
      end
      want = expected_verdicts.pop_front();
      verdicts_checked++;
      if (got !== want)
        flag($sformatf("result %0d: expected deadlock=%b, got %b",
                       verdicts_checked, want, got));
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] mode;
  logic [4:0] proc_id;
  logic [3:0] lock_id;
  logic       out_valid;
  logic       out_stall;
  logic       deadlock;

  deadlock_tracker graph_model = new();
  int items_sent;
  int gap_style;
  int stall_style;
  int burst_left;
  int pool_proc;
  int pool_lock;
  int idle_cycles;
  bit hold_req;

  rag_deadlock_detector_unit #(
    .NUM_LOCKS(LOCKS),
    .NUM_PROCS(PROCS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .proc_id(proc_id),
    .lock_id(lock_id),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .deadlock(deadlock)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid === 1'b1 && in_stall === 1'b0)
        graph_model.note_transfer(mode, proc_id, lock_id);
      if (out_valid === 1'b1 && out_stall === 1'b0)
        graph_model.check_verdict(deadlock);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, graph_model.pending());
        $display("FAIL rag_deadlock_detector_unit");
        $finish;
      end
    end
  end

  initial begin : receiver
    int hold_left;
    int phase;
    hold_left = 0;
    phase = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_left == 0 && hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= (phase % 11) < 4;
        endcase
      end
    end
  end

  function automatic logic [4:0] pick_proc();
    if ($urandom_range(0, 4) == 0) return 5'($urandom_range(0, 31));
    return 5'(pool_proc + $urandom_range(0, 5));
  endfunction

  function automatic logic [3:0] pick_lock();
    if ($urandom_range(0, 4) == 0) return 4'($urandom_range(0, 15));
    return 4'(pool_lock + $urandom_range(0, 5));
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [4:0] p, input logic [3:0] l);
    int gap;
    in_valid <= 1'b1;
    mode <= op;
    proc_id <= p;
    lock_id <= l;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = (gap_style == 0) ? 0 : $urandom_range(1, (gap_style == 1) ? 4 : 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        mode <= 2'($urandom_range(0, 3));
        proc_id <= 5'($urandom_range(0, 31));
        lock_id <= 4'($urandom_range(0, 15));
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (graph_model.pending() != 0) @(posedge clk);
  endtask

  task automatic clear_graph();
    int p, l;
    drain();
    for (p = 0; p < PROCS; p++)
      for (l = 0; l < LOCKS; l++)
        if (graph_model.wants[p][l] || graph_model.holders[l][p])
          send_item(MODE_DEALLOC, 5'(p), 4'(l));
    send_item(MODE_DETECT, pick_proc(), pick_lock());
  endtask

  task automatic random_ops(input int count, input bit wild);
    int n, r;
    logic [1:0] op;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 19);
      if (r < 7) op = MODE_REQUEST;
      else if (r < 13) op = MODE_ALLOC;
      else if (r < 17) op = MODE_DEALLOC;
      else op = MODE_DETECT;
      if (wild)
        send_item(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                  4'($urandom_range(0, 15)));
      else
        send_item(op, pick_proc(), pick_lock());
    end
  endtask

  // each process holds one lock and waits on the next one in the ring
  task automatic build_cycle();
    int k, n, pb, ps, lb;
    n = $urandom_range(1, 6);
    pb = $urandom_range(0, 31);
    ps = 2 * $urandom_range(0, 15) + 1;
    lb = $urandom_range(0, 15);
    for (k = 0; k < n; k++)
      send_item(MODE_ALLOC, 5'(pb + k * ps), 4'(lb + k));
    if ($urandom_range(0, 3) == 0) random_ops(1, 0);
    for (k = 0; k < n; k++)
      send_item(MODE_REQUEST, 5'(pb + k * ps), 4'(lb + (k + 1) % n));
    send_item(MODE_DETECT, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)));
    if ($urandom_range(0, 1) == 0) begin
      k = $urandom_range(0, n - 1);
      if ($urandom_range(0, 1) == 0)
        send_item(MODE_DEALLOC, 5'(pb + k * ps), 4'(lb + k));
      else
        send_item(MODE_DEALLOC, 5'(pb + k * ps), 4'(lb + (k + 1) % n));
      send_item(MODE_DETECT, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_REQUEST;
    proc_id = '0;
    lock_id = '0;
    items_sent = 0;
    gap_style = 0;
    stall_style = 0;
    burst_left = 0;
    pool_proc = 0;
    pool_lock = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_item(MODE_DETECT, 5'd31, 4'd15);
    send_item(MODE_REQUEST, 5'd31, 4'd15);
    send_item(MODE_REQUEST, 5'd31, 4'd15);
    send_item(MODE_ALLOC, 5'd31, 4'd15);
    send_item(MODE_DETECT, 5'd0, 4'd0);
    send_item(MODE_DEALLOC, 5'd31, 4'd15);
    send_item(MODE_DEALLOC, 5'd31, 4'd15);
    send_item(MODE_ALLOC, 5'd0, 4'd0);
    send_item(MODE_ALLOC, 5'd1, 4'd0);
    send_item(MODE_ALLOC, 5'd1, 4'd1);
    send_item(MODE_REQUEST, 5'd0, 4'd1);
    send_item(MODE_REQUEST, 5'd1, 4'd0);
    send_item(MODE_DETECT, 5'd0, 4'd0);
    send_item(MODE_DEALLOC, 5'd1, 4'd1);
    send_item(MODE_DETECT, 5'd0, 4'd0);
    // two paths from one process meet at a single lock: these edges form no cycle
    send_item(MODE_REQUEST, 5'd2, 4'd2);
    send_item(MODE_REQUEST, 5'd2, 4'd3);
    send_item(MODE_ALLOC, 5'd3, 4'd2);
    send_item(MODE_ALLOC, 5'd4, 4'd3);
    send_item(MODE_REQUEST, 5'd3, 4'd4);
    send_item(MODE_REQUEST, 5'd4, 4'd4);
    send_item(MODE_ALLOC, 5'd5, 4'd4);
    send_item(MODE_DETECT, 5'd0, 4'd0);
    send_item(MODE_ALLOC, 5'd2, 4'd4);
    send_item(MODE_DETECT, 5'd0, 4'd0);
    drain();
    clear_graph();

    hold_req = 1'b1;
    random_ops(12, 0);
    drain();

    while (items_sent < ITEM_TARGET) begin
      gap_style = $urandom_range(0, 2);
      stall_style = $urandom_range(0, 3);
      pool_proc = ($urandom_range(0, 1) == 0) ? 0 : 26;
      pool_lock = ($urandom_range(0, 1) == 0) ? 0 : 10;
      case ($urandom_range(0, 11))
        0, 1, 2, 3: build_cycle();
        4, 5, 6: random_ops($urandom_range(5, 15), 0);
        7: random_ops($urandom_range(3, 8), 1);
        8: clear_graph();
        9: begin
          drain();
          random_ops($urandom_range(2, 6), 0);
        end
        10: begin
          hold_req = 1'b1;
          random_ops(10, 0);
        end
        default: begin
          gap_style = 0;
          stall_style = 0;
          build_cycle();
        end
      endcase
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d transfers in, %0d results checked; %0d detects, %0d with a cycle",
             items_sent, graph_model.verdicts_checked, graph_model.detects_run,
             graph_model.cycles_found);
    if (graph_model.errors > 10)
      $display("%0d mismatches in total", graph_model.errors);
    if (graph_model.errors == 0 && graph_model.pending() == 0)
      $display("PASS rag_deadlock_detector_unit");
    else
      $display("FAIL rag_deadlock_detector_unit");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/rdd_pkg.sv
hdl/rdd_ram.sv
hdl/rdd_prune.sv
hdl/rdd_ctrl.sv
hdl/rag_deadlock_detector_unit.sv
sim/testbench.sv
